// ----- sv/dros_pkg.sv -----
// Shared types, constants and tables for the daylight-saving offset selector.
// Used by dst_rule_offset_select; depends on nothing else.
package dros_pkg;

    // Rule storage limits; a rule count above either bound is clamped.
    localparam int MAX_RULES  = 4;
    localparam int RULE_REGS  = 4;
    localparam int RULE_LIMIT = (MAX_RULES < RULE_REGS) ? MAX_RULES : RULE_REGS;

    // Field widths of a request and a result.
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int OFFSET_W = 18;
    localparam int COUNT_W  = 3;

    // Configuration port geometry: 64-bit data, registers on 8-byte steps.
    localparam int PDATA_W = 64;
    localparam int PADDR_W = 6;
    localparam int RULE_W  = 33;

    // Division of the quarter year by 25 as a reciprocal multiply.
    // The estimate is low by at most one and is corrected by one compare.
    localparam int RECIP_25 = 1310;
    localparam int RECIP_SH = 15;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_RULE_COUNT = 3'd0,
        REG_RULE_0     = 3'd1,
        REG_RULE_1     = 3'd2,
        REG_RULE_2     = 3'd3,
        REG_RULE_3     = 3'd4
    } reg_idx_t;

    // One rule register, packed as it is written.
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [4:0]          hour;
        logic [2:0]          occ;
        logic [2:0]          wday;
        logic [3:0]          month;
    } rule_t;

    // Query fields that travel down the pipeline unchanged.
    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
    } query_t;

    // Month offsets of the day-of-week method; months outside 1..12 give 0.
    function automatic logic [2:0] month_code(input logic [MONTH_W-1:0] m);
        logic [2:0] c;
        case (m)
            4'd1:    c = 3'd0;
            4'd2:    c = 3'd3;
            4'd3:    c = 3'd2;
            4'd4:    c = 3'd5;
            4'd5:    c = 3'd0;
            4'd6:    c = 3'd3;
            4'd7:    c = 3'd5;
            4'd8:    c = 3'd1;
            4'd9:    c = 3'd4;
            4'd10:   c = 3'd6;
            4'd11:   c = 3'd2;
            4'd12:   c = 3'd4;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/dst_rule_offset_select.sv -----
// Daylight-saving rule offset selector: seven-stage pipeline and rule registers.
// Depends on dros_pkg for types, constants and the month table.
//
//   channel   ports                               handshake
//   request   year, month, day, hour              start (accepted when busy low)
//   result    utc_offset                          done, one cycle, no back-pressure
//   config    psel penable pwrite paddr pwdata    APB write and read, pready tied high
//             prdata
//
// A request is accepted in every cycle; busy is never raised.
// Each result passes through the seven register stages: year adjust, reciprocal
// multiply, quotient correction, day-of-week sum, mod-7 reduction, per-rule date
// compare, and offset selection.
// Reset clears the pipeline valid bits, the rule count and the rule registers.
// Nothing stalls: results leave on done and the receiver takes each one.
module dst_rule_offset_select (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dros_pkg::YEAR_W-1:0]   year,
    input  logic [dros_pkg::MONTH_W-1:0]  month,
    input  logic [dros_pkg::DAY_W-1:0]    day,
    input  logic [dros_pkg::HOUR_W-1:0]   hour,
    output logic                          done,
    output logic [dros_pkg::OFFSET_W-1:0] utc_offset,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dros_pkg::PADDR_W-1:0]  paddr,
    input  logic [dros_pkg::PDATA_W-1:0]  pwdata,
    output logic [dros_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import dros_pkg::*;

    // Configuration registers.
    logic [COUNT_W-1:0] rule_count_reg;
    rule_t              rule_reg [RULE_REGS];
    logic [2:0]         cfg_idx;
    logic               cfg_wr;

    // Pipeline valid bits.
    logic [7:1] valid_reg;
    logic       accept;

    // Stage registers and their next values.
    query_t      qry_reg [1:5];
    logic [15:0] s1_y_reg, s1_y_next;
    logic [13:0] s1_q4_reg, s1_q4_next;
    logic [2:0]  s1_code_reg, s1_code_next;
    logic [15:0] s2_y_reg;
    logic [13:0] s2_q4_reg;
    logic [2:0]  s2_code_reg;
    logic [9:0]  s2_qe_reg, s2_qe_next;
    logic [15:0] s3_y_reg;
    logic [13:0] s3_q4_reg;
    logic [2:0]  s3_code_reg;
    logic [9:0]  s3_cent_reg, s3_cent_next;
    logic [5:0]  s4_fold_reg, s4_fold_next;
    logic [2:0]  s5_first_reg, s5_first_next;
    logic [RULE_REGS-1:0] s6_take_reg, s6_take_next;
    logic [OFFSET_W-1:0]  offset_reg, offset_next;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Register write decode: one register per 8-byte slot.
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
            for (int i = 0; i < RULE_REGS; i++)
            begin
                rule_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_RULE_COUNT: rule_count_reg <= pwdata[COUNT_W-1:0];
                REG_RULE_0:     rule_reg[0] <= rule_t'(pwdata[RULE_W-1:0]);
                REG_RULE_1:     rule_reg[1] <= rule_t'(pwdata[RULE_W-1:0]);
                REG_RULE_2:     rule_reg[2] <= rule_t'(pwdata[RULE_W-1:0]);
                REG_RULE_3:     rule_reg[3] <= rule_t'(pwdata[RULE_W-1:0]);
                default:        ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (cfg_idx)
            REG_RULE_COUNT: prdata = PDATA_W'(rule_count_reg);
            REG_RULE_0:     prdata = PDATA_W'(rule_reg[0]);
            REG_RULE_1:     prdata = PDATA_W'(rule_reg[1]);
            REG_RULE_2:     prdata = PDATA_W'(rule_reg[2]);
            REG_RULE_3:     prdata = PDATA_W'(rule_reg[3]);
            default:        prdata = '0;
        endcase
    end

    // Stage 1: year adjusted for January and February, quarter year, month code.
    always_comb
    begin
        if (month < 4'd3)
        begin
            s1_y_next = 16'(year) - 16'd1;
        end
        else
        begin
            s1_y_next = 16'(year);
        end
        s1_q4_next   = s1_y_next[15:2];
        s1_code_next = month_code(month);
    end

    // Stage 2: low estimate of the century count from the quarter year.
    always_comb
    begin
        logic [24:0] prod;
        prod       = 25'(s1_q4_reg) * 25'(RECIP_25);
        s2_qe_next = prod[RECIP_SH +: 10];
    end

    // Stage 3: correct the estimate so that it is exactly year / 100.
    always_comb
    begin
        logic [14:0] rem;
        rem = 15'(s2_q4_reg) - 15'(s2_qe_reg) * 15'd25;
        if (rem >= 15'd25)
        begin
            s3_cent_next = s2_qe_reg + 10'd1;
        end
        else
        begin
            s3_cent_next = s2_qe_reg;
        end
    end

    // Stage 4: day-of-week sum for the first of the month, folded on octal digits.
    always_comb
    begin
        logic [17:0] sum;
        sum = 18'(s3_y_reg) + 18'(s3_q4_reg) + 18'(s3_cent_reg[9:2])
            + 18'(s3_code_reg) + 18'd1 - 18'(s3_cent_reg);
        s4_fold_next = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6])
                     + 6'(sum[11:9]) + 6'(sum[14:12]) + 6'(sum[17:15]);
    end

    // Stage 5: finish the reduction modulo 7 to get the weekday of the first.
    always_comb
    begin
        logic [3:0] f2;
        f2 = 4'(s4_fold_reg[5:3]) + 4'(s4_fold_reg[2:0]);
        if (f2 >= 4'd7)
        begin
            s5_first_next = 3'(f2 - 4'd7);
        end
        else
        begin
            s5_first_next = f2[2:0];
        end
    end

    // Stage 6: per rule, find the Nth weekday date and decide whether it applies.
    always_comb
    begin
        logic [COUNT_W-1:0] cnt;
        logic [2:0]         target;
        logic [3:0]         diff;
        logic [2:0]         wofs;
        logic [7:0]         date;
        logic [7:0]         day8;
        query_t             q;
        cnt = (rule_count_reg > COUNT_W'(RULE_LIMIT)) ? COUNT_W'(RULE_LIMIT)
                                                      : rule_count_reg;
        q    = qry_reg[5];
        day8 = 8'(q.day);
        s6_take_next = '0;
        for (int i = 0; i < RULE_REGS; i++)
        begin
            target = (rule_reg[i].wday == 3'd7) ? 3'd0 : rule_reg[i].wday;
            diff   = 4'(target) + 4'd7 - 4'(s5_first_reg);
            wofs   = (diff >= 4'd7) ? 3'(diff - 4'd7) : diff[2:0];
            date   = 8'(wofs) + 8'(rule_reg[i].occ) * 8'd7 - 8'd6;
            if (COUNT_W'(i) < cnt)
            begin
                if (q.month > rule_reg[i].month)
                begin
                    s6_take_next[i] = 1'b1;
                end
                else if (q.month == rule_reg[i].month)
                begin
                    s6_take_next[i] = (day8 > date)
                        || ((day8 == date) && (q.hour >= rule_reg[i].hour));
                end
            end
        end
    end

    // Stage 7: the highest applying rule wins; none gives zero.
    always_comb
    begin
        offset_next = '0;
        for (int i = 0; i < RULE_REGS; i++)
        begin
            if (s6_take_reg[i])
            begin
                offset_next = rule_reg[i].offset;
            end
        end
    end

    // Valid bits advance every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[6:1], accept};
        end
    end

    // Payload stage registers, no reset.
    always_ff @(posedge clk)
    begin
        qry_reg[1]   <= '{month: month, day: day, hour: hour};
        for (int s = 2; s <= 5; s++)
        begin
            qry_reg[s] <= qry_reg[s-1];
        end
        s1_y_reg     <= s1_y_next;
        s1_q4_reg    <= s1_q4_next;
        s1_code_reg  <= s1_code_next;
        s2_y_reg     <= s1_y_reg;
        s2_q4_reg    <= s1_q4_reg;
        s2_code_reg  <= s1_code_reg;
        s2_qe_reg    <= s2_qe_next;
        s3_y_reg     <= s2_y_reg;
        s3_q4_reg    <= s2_q4_reg;
        s3_code_reg  <= s2_code_reg;
        s3_cent_reg  <= s3_cent_next;
        s4_fold_reg  <= s4_fold_next;
        s5_first_reg <= s5_first_next;
        s6_take_reg  <= s6_take_next;
        offset_reg   <= offset_next;
    end

    assign done       = valid_reg[7];
    assign utc_offset = offset_reg;

`ifndef NO_ASSERTIONS
    // Every result traces back to an accepted request.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 7))
        else $error("result without a matching request");

    // The corrected quotient is exactly the century count of the adjusted year.
    a_century: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> ((17'(s3_cent_reg) * 17'd100 <= 17'(s3_y_reg))
            && (17'(s3_y_reg) < 17'(s3_cent_reg) * 17'd100 + 17'd100)))
        else $error("century quotient out of step with the year");

    // The weekday of the first of the month is a real weekday.
    a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |-> (s5_first_reg != 3'd7))
        else $error("weekday reduction left a value of seven");

    // When no rule applied, the offset is zero.
    a_no_rule: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[6] && (s6_take_reg == '0)) |=> (utc_offset == '0))
        else $error("nonzero offset with no applying rule");
`endif

endmodule

// ----- sim/dst_rule_offset_select_tb.sv -----
// Self-checking testbench for the daylight-saving rule offset selector.
// Needs dros_pkg and dst_rule_offset_select; it drives date requests and rule
// writes, then checks every offset against a table value or an in-bench rule evaluator.
module dst_rule_offset_select_tb;
    import dros_pkg::*;

    localparam int LATENCY        = 7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 75;
    localparam int DIRECTED_ROWS  = 25;

    // Month offsets of the day-of-week method, January first.
    localparam int unsigned DOW_MONTH_SHIFT [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    // One row of the directed table: a date request or a register write.
    typedef enum logic [1:0] {
        ROW_QUERY,
        ROW_COUNT,
        ROW_RULE
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        reg_idx_t           idx;
        logic [COUNT_W-1:0] count;
        rule_t              rule;
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mo;
        logic [DAY_W-1:0]   dy;
        logic [HOUR_W-1:0]  hr;
        logic               typed;
        logic [OFFSET_W-1:0] want;
    } step_t;

    // Rule set used in the middle of the table:
    //   rule 0: month zero, weekday seven, occurrence zero, largest offset
    //   rule 1: second Sunday of March at 2, one hour
    //   rule 2: first Sunday of November at 2, most negative offset
    //   rule 3: month fifteen, weekday seven, occurrence seven, minus one hour
    localparam step_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd1,    4'd1,  5'd1,  5'd0,  1'b1, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd4095, 4'd12, 5'd31, 5'd23, 1'b1, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd0,    4'd15, 5'd31, 5'd31, 1'b1, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd0,    4'd0,  5'd0,  5'd0,  1'b1, 18'd0},
        '{ROW_RULE, REG_RULE_0, 3'd0, '{18'h1FFFF, 5'd0, 3'd0, 3'd7, 4'd0},
          12'd0, 4'd0, 5'd0, 5'd0, 1'b0, 18'd0},
        '{ROW_RULE, REG_RULE_1, 3'd0, '{18'd3600, 5'd2, 3'd2, 3'd0, 4'd3},
          12'd0, 4'd0, 5'd0, 5'd0, 1'b0, 18'd0},
        '{ROW_RULE, REG_RULE_2, 3'd0, '{18'h20000, 5'd2, 3'd1, 3'd0, 4'd11},
          12'd0, 4'd0, 5'd0, 5'd0, 1'b0, 18'd0},
        '{ROW_RULE, REG_RULE_3, 3'd0, '{18'h3F1F0, 5'd31, 3'd7, 3'd7, 4'd15},
          12'd0, 4'd0, 5'd0, 5'd0, 1'b0, 18'd0},
        '{ROW_COUNT, REG_RULE_COUNT, 3'd7, '0, 12'd0, 4'd0, 5'd0, 5'd0, 1'b0, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd0,    4'd1,  5'd1,  5'd0,  1'b1, 18'h1FFFF},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd2024, 4'd3,  5'd10, 5'd2,  1'b1, 18'd3600},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd2024, 4'd3,  5'd10, 5'd1,  1'b1, 18'h1FFFF},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd2024, 4'd11, 5'd3,  5'd2,  1'b1, 18'h20000},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd2024, 4'd12, 5'd31, 5'd23, 1'b1, 18'h20000},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd0,    4'd0,  5'd0,  5'd0,  1'b0, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd0,    4'd0,  5'd31, 5'd31, 1'b0, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd4095, 4'd15, 5'd31, 5'd31, 1'b0, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd1,    4'd15, 5'd0,  5'd0,  1'b0, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd2000, 4'd2,  5'd29, 5'd12, 1'b0, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd1900, 4'd3,  5'd11, 5'd5,  1'b0, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd2024, 4'd11, 5'd2,  5'd23, 1'b0, 18'd0},
        '{ROW_COUNT, REG_RULE_COUNT, 3'd0, '0, 12'd0, 4'd0, 5'd0, 5'd0, 1'b0, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd2024, 4'd6,  5'd15, 5'd12, 1'b1, 18'd0},
        '{ROW_COUNT, REG_RULE_COUNT, 3'd1, '0, 12'd0, 4'd0, 5'd0, 5'd0, 1'b0, 18'd0},
        '{ROW_QUERY, REG_RULE_COUNT, 3'd0, '0, 12'd2024, 4'd6,  5'd15, 5'd12, 1'b1, 18'h1FFFF}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [YEAR_W-1:0]   year = '0;
    logic [MONTH_W-1:0]  month = '0;
    logic [DAY_W-1:0]    day = '0;
    logic [HOUR_W-1:0]   hour = '0;
    logic                done;
    logic [OFFSET_W-1:0] utc_offset;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Shadow copy of the rule registers as the evaluator sees them.
    logic [COUNT_W-1:0]  shadow_count;
    rule_t               shadow_rules [RULE_REGS];

    logic [OFFSET_W-1:0] pending_offsets [$];
    bit                  idle_enable;
    int                  fail_count;
    int                  requests_sent;
    int                  directed_sent;
    int                  offsets_checked;
    int                  settings_used;
    int                  stall_cycles = 0;

    dst_rule_offset_select u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .year       (year),
        .month      (month),
        .day        (day),
        .hour       (hour),
        .done       (done),
        .utc_offset (utc_offset),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Weekday of the first of a month, Sunday is 0; the year before March is
    // taken one lower and wraps within 16 bits.
    function automatic int unsigned first_weekday(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m);
        int unsigned yy;
        int unsigned shift;
        yy = 32'(y);
        if (m < 4'd3)
            yy = (yy - 1) & 32'hFFFF;
        shift = (m >= 4'd1 && m <= 4'd12) ? DOW_MONTH_SHIFT[int'(m) - 1] : 0;
        return (yy + yy / 4 + yy / 400 + shift + 1 - yy / 100) % 7;
    endfunction

    // Date of the Nth given weekday; kept to 8 bits, so occurrence zero wraps.
    function automatic int unsigned nth_weekday_date(input logic [YEAR_W-1:0] y,
                                                     input logic [MONTH_W-1:0] m,
                                                     input logic [2:0] wday,
                                                     input logic [2:0] occ);
        int unsigned first;
        int unsigned target;
        int unsigned nth;
        int unsigned date;
        first  = first_weekday(y, m);
        target = int'(wday) % 7;
        nth    = 32'(occ);
        date   = 1 + (target + 7 - first) % 7;
        return (date + (nth - 1) * 7) & 32'hFF;
    endfunction

    // Offset of the last rule whose start the date has reached, else zero.
    function automatic logic [OFFSET_W-1:0] predict_offset(input logic [YEAR_W-1:0] y,
                                                           input logic [MONTH_W-1:0] m,
                                                           input logic [DAY_W-1:0] d,
                                                           input logic [HOUR_W-1:0] h);
        int unsigned         active;
        int unsigned         date;
        logic [OFFSET_W-1:0] pick;
        rule_t               r;
        active = 32'(shadow_count);
        if (active > RULE_LIMIT)
            active = RULE_LIMIT;
        pick = '0;
        for (int i = 0; i < active; i++)
        begin
            r = shadow_rules[i];
            if (m > r.month)
                pick = r.offset;
            else if (m == r.month)
            begin
                date = nth_weekday_date(y, r.month, r.wday, r.occ);
                if (32'(d) > date || (32'(d) == date && h >= r.hour))
                    pick = r.offset;
            end
        end
        return pick;
    endfunction

    // Write one register, read it straight back, and update the shadow copy.
    task automatic write_register(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] want;
        want = (idx == REG_RULE_COUNT) ? PDATA_W'(data[COUNT_W-1:0])
                                       : PDATA_W'(data[RULE_W-1:0]);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // Back-to-back read of the same register.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("prdata expected %h got %h", want, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_RULE_COUNT)
            shadow_count = data[COUNT_W-1:0];
        else
            shadow_rules[int'(idx) - 1] = data[RULE_W-1:0];
    endtask

    // Present one date request, idling first at random, and record its offset.
    task automatic send_request(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                                input logic [DAY_W-1:0] d, input logic [HOUR_W-1:0] h,
                                input bit typed, input logic [OFFSET_W-1:0] want);
        while (idle_enable && $urandom_range(0, 99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        year  <= y;
        month <= m;
        day   <= d;
        hour  <= h;
        do @(posedge clk); while (busy);
        pending_offsets.push_back(typed ? want : predict_offset(y, m, d, h));
        requests_sent++;
    endtask

    // Stop requesting and let every outstanding offset come back.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_offsets.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed rules with random content, plus all-ones, zero and raw.
    function automatic rule_t random_rule();
        rule_t r;
        int    off;
        int    sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            r = '1;
        else if (sel == 1)
            r = '0;
        else if (sel == 2)
            r = rule_t'(RULE_W'({$urandom, $urandom}));
        else
        begin
            r.month = MONTH_W'($urandom_range(1, 12));
            r.wday  = 3'($urandom_range(0, 6));
            r.occ   = 3'($urandom_range(1, 5));
            r.hour  = HOUR_W'($urandom_range(0, 23));
            off     = int'($urandom_range(0, 36000)) - 18000;
            r.offset = OFFSET_W'(off);
            if ($urandom_range(0, 4) == 0)
                r.offset = $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
        end
        return r;
    endfunction

    // Most requests land on or next to a rule's switch-over; the rest are
    // plain dates or raw bit patterns.
    task automatic random_request();
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
        logic [HOUR_W-1:0]  h;
        rule_t              r;
        int unsigned        date;
        int                 sel;
        sel = $urandom_range(0, 99);
        y = ($urandom_range(0, 9) == 0) ? YEAR_W'($urandom_range(0, 4095))
                                        : YEAR_W'($urandom_range(1900, 2100));
        if (sel < 70)
        begin
            r    = shadow_rules[$urandom_range(0, RULE_REGS - 1)];
            date = nth_weekday_date(y, r.month, r.wday, r.occ);
            m    = r.month;
            if ($urandom_range(0, 4) == 0)
                m = $urandom_range(0, 1) ? m + 4'd1 : m - 4'd1;
            d = DAY_W'(date + $urandom_range(0, 2) - 1);
            h = HOUR_W'(int'(r.hour) + int'($urandom_range(0, 2)) - 1);
        end
        else if (sel < 90)
        begin
            m = MONTH_W'($urandom_range(1, 12));
            d = DAY_W'($urandom_range(1, 31));
            h = HOUR_W'($urandom_range(0, 23));
        end
        else
        begin
            y = YEAR_W'($urandom);
            m = MONTH_W'($urandom);
            d = DAY_W'($urandom);
            h = HOUR_W'($urandom);
        end
        send_request(y, m, d, h, 1'b0, '0);
    endtask

    // Every done carries one offset; compare it with the oldest one expected.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_offsets.size() == 0)
            begin
                $error("utc_offset unexpected result %0d", $signed(utc_offset));
                fail_count++;
            end
            else
            begin
                if (utc_offset !== pending_offsets[0])
                begin
                    $error("utc_offset expected %0d got %0d",
                           $signed(pending_offsets[0]), $signed(utc_offset));
                    fail_count++;
                end
                void'(pending_offsets.pop_front());
                offsets_checked++;
            end
        end
    end

    // Watchdog on cycles where no request, result or register access moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("dst_rule_offset_select_tb failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int count_pick;
        shadow_count = '0;
        for (int i = 0; i < RULE_REGS; i++)
            shadow_rules[i] = '0;
        idle_enable     = 1'b1;
        fail_count      = 0;
        requests_sent   = 0;
        directed_sent   = 0;
        offsets_checked = 0;
        settings_used   = 1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset state, field extremes and the odd rule encodings.
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_QUERY)
                send_request(DIRECTED[i].yr, DIRECTED[i].mo, DIRECTED[i].dy,
                             DIRECTED[i].hr, DIRECTED[i].typed, DIRECTED[i].want);
            else
            begin
                drain_results();
                if (DIRECTED[i].kind == ROW_COUNT)
                begin
                    write_register(REG_RULE_COUNT, PDATA_W'(DIRECTED[i].count));
                    settings_used++;
                end
                else
                    write_register(DIRECTED[i].idx, PDATA_W'(DIRECTED[i].rule));
            end
        end
        directed_sent = requests_sent;

        // Random phases, each under a fresh rule set; two phases run without gaps.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            write_register(REG_RULE_0, PDATA_W'(random_rule()));
            write_register(REG_RULE_1, PDATA_W'(random_rule()));
            write_register(REG_RULE_2, PDATA_W'(random_rule()));
            write_register(REG_RULE_3, PDATA_W'(random_rule()));
            case (p)
                0:       count_pick = 4;
                1:       count_pick = 7;
                2:       count_pick = 1;
                3:       count_pick = 0;
                default: count_pick = $urandom_range(0, 7);
            endcase
            write_register(REG_RULE_COUNT, PDATA_W'(count_pick));
            settings_used++;
            idle_enable = !(p == 4 || p == 5);
            for (int n = 0; n < PHASE_REQUESTS; n++)
                random_request();
        end

        drain_results();
        repeat (LATENCY + 3) @(posedge clk);
        if (pending_offsets.size() != 0)
        begin
            $error("utc_offset %0d results never arrived", pending_offsets.size());
            fail_count++;
        end

        $display("Ran %0d date requests (%0d from the directed table) under %0d rule settings;",
                 requests_sent, directed_sent, settings_used);
        $display("%0d offsets compared, %0d mismatches.", offsets_checked, fail_count);
        if (fail_count == 0)
            $display("dst_rule_offset_select_tb passed");
        else
            $display("dst_rule_offset_select_tb failed");
        $finish;
    end

endmodule
